// ----- src/tagged_field_serializer_defines.svh -----
// Assertion macros for the tagged field serializer.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef TAGGED_FIELD_SERIALIZER_DEFINES_SVH
`define TAGGED_FIELD_SERIALIZER_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define TFS_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`define TFS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`else

`define TFS_ASSERT_SAME(lbl, ante, cons, msg)

`define TFS_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ----- src/tfs_pkg.sv -----
package tfs_pkg;

	// Longest encoding: escaped tag head plus an eight-byte integer.
	localparam int TFS_NBYTES  = 10;
	localparam int TFS_BYTES_W = TFS_NBYTES * 8;
	localparam int TFS_CNT_W   = $clog2(TFS_NBYTES + 1);

	// Transaction queue between the encoder and the byte sequencer.
	localparam int TFS_QDEPTH = 4;
	localparam int TFS_QPTR_W = $clog2(TFS_QDEPTH);
	localparam int TFS_QCNT_W = $clog2(TFS_QDEPTH + 1);

	// Actions.
	localparam logic [2:0] ACT_INT       = 3'd0;
	localparam logic [2:0] ACT_STRING    = 3'd1;
	localparam logic [2:0] ACT_BYTEARRAY = 3'd2;
	localparam logic [2:0] ACT_STRUCT_BEG = 3'd3;
	localparam logic [2:0] ACT_STRUCT_END = 3'd4;
	localparam logic [2:0] ACT_LIST      = 3'd5;
	localparam logic [2:0] ACT_MAP       = 3'd6;
	localparam logic [2:0] ACT_RAW       = 3'd7;

	// Type codes in the low nibble of a head byte.
	localparam logic [3:0] TY_INT1       = 4'd0;
	localparam logic [3:0] TY_INT2       = 4'd1;
	localparam logic [3:0] TY_INT4       = 4'd2;
	localparam logic [3:0] TY_INT8       = 4'd3;
	localparam logic [3:0] TY_STR1       = 4'd6;
	localparam logic [3:0] TY_STR4       = 4'd7;
	localparam logic [3:0] TY_MAP        = 4'd8;
	localparam logic [3:0] TY_LIST       = 4'd9;
	localparam logic [3:0] TY_STRUCT_BEG = 4'd10;
	localparam logic [3:0] TY_STRUCT_END = 4'd11;
	localparam logic [3:0] TY_ZERO       = 4'd12;
	localparam logic [3:0] TY_SIMPLE     = 4'd13;

	// Tags from this value up go in an extra byte after the head.
	localparam logic [7:0] TAG_ESC    = 8'd15;
	localparam logic [3:0] TAG_ESC_NB = 4'hF;

	localparam logic [30:0] STR1_MAX   = 31'd255;
	localparam logic [30:0] COUNT_MAX  = 31'd255;
	localparam logic [30:0] BARRAY_MAX = 31'd32767;

	// One encoded transaction. While it is built, bytes shift in from the
	// bottom; the encoder then left-justifies it so the first byte is on top.
	typedef struct packed {
		logic                   err;
		logic [TFS_CNT_W-1:0]   cnt;
		logic [TFS_BYTES_W-1:0] bytes;
	} tfs_desc_t;

	typedef struct packed {
		logic                  full;
		logic                  empty;
		logic [TFS_QCNT_W-1:0] count;
	} tfs_qstat_t;

	function automatic tfs_desc_t tfs_put(tfs_desc_t d, logic [7:0] b);
		tfs_desc_t r;
		r       = d;
		r.bytes = {d.bytes[TFS_BYTES_W-9:0], b};
		r.cnt   = d.cnt + TFS_CNT_W'(1);
		return r;
	endfunction

	function automatic tfs_desc_t tfs_head(tfs_desc_t d, logic [3:0] ty, logic [7:0] tg);
		tfs_desc_t r;
		if (tg < TAG_ESC) begin
			r = tfs_put(d, {tg[3:0], ty});
		end else begin
			r = tfs_put(d, {TAG_ESC_NB, ty});
			r = tfs_put(r, tg);
		end
		return r;
	endfunction

	// Narrowest signed form: zero, then 1, 2, 4 or 8 big-endian bytes.
	function automatic tfs_desc_t tfs_put_int(tfs_desc_t d, logic [63:0] v, logic [7:0] tg);
		tfs_desc_t r;
		logic      fit8;
		logic      fit16;
		logic      fit32;
		fit8  = (&v[63:7])  | ~(|v[63:7]);
		fit16 = (&v[63:15]) | ~(|v[63:15]);
		fit32 = (&v[63:31]) | ~(|v[63:31]);
		if (v == 64'd0) begin
			r = tfs_head(d, TY_ZERO, tg);
		end else if (fit8) begin
			r = tfs_head(d, TY_INT1, tg);
			r = tfs_put(r, v[7:0]);
		end else if (fit16) begin
			r = tfs_head(d, TY_INT2, tg);
			r = tfs_put(r, v[15:8]);
			r = tfs_put(r, v[7:0]);
		end else if (fit32) begin
			r = tfs_head(d, TY_INT4, tg);
			for (int i = 3; i >= 0; i--) begin
				r = tfs_put(r, v[8*i +: 8]);
			end
		end else begin
			r = tfs_head(d, TY_INT8, tg);
			for (int i = 7; i >= 0; i--) begin
				r = tfs_put(r, v[8*i +: 8]);
			end
		end
		return r;
	endfunction

endpackage

// ----- src/tfs_front.sv -----
// Accepts a command and encodes it into a complete byte sequence.
module tfs_front (
	input  logic                      start,
	output logic                      busy,
	input  logic [2:0]                action,
	input  logic [7:0]                tag,
	input  logic signed [63:0]        value,
	input  logic [30:0]               length,
	input  tfs_pkg::tfs_qstat_t       q_stat,
	output logic                      push,
	output tfs_pkg::tfs_desc_t        desc
);

	tfs_pkg::tfs_desc_t enc;
	logic [tfs_pkg::TFS_CNT_W-1:0] pad;

	assign busy = q_stat.full;
	assign push = start & ~q_stat.full;

	always_comb begin
		enc = '0;
		unique case (action) inside
			tfs_pkg::ACT_INT: begin
				enc = tfs_pkg::tfs_put_int(enc, value, tag);
			end
			tfs_pkg::ACT_STRING: begin
				if (length > tfs_pkg::STR1_MAX) begin
					enc = tfs_pkg::tfs_head(enc, tfs_pkg::TY_STR4, tag);
					enc = tfs_pkg::tfs_put(enc, {1'b0, length[30:24]});
					enc = tfs_pkg::tfs_put(enc, length[23:16]);
					enc = tfs_pkg::tfs_put(enc, length[15:8]);
					enc = tfs_pkg::tfs_put(enc, length[7:0]);
				end else begin
					enc = tfs_pkg::tfs_head(enc, tfs_pkg::TY_STR1, tag);
					enc = tfs_pkg::tfs_put(enc, length[7:0]);
				end
			end
			tfs_pkg::ACT_BYTEARRAY: begin
				if (length > tfs_pkg::BARRAY_MAX) begin
					enc.err = 1'b1;
					enc     = tfs_pkg::tfs_put(enc, 8'h00);
				end else begin
					enc = tfs_pkg::tfs_head(enc, tfs_pkg::TY_SIMPLE, tag);
					enc = tfs_pkg::tfs_head(enc, tfs_pkg::TY_INT1, 8'd0);
					enc = tfs_pkg::tfs_put_int(enc, {33'd0, length}, 8'd0);
				end
			end
			tfs_pkg::ACT_STRUCT_BEG: begin
				enc = tfs_pkg::tfs_head(enc, tfs_pkg::TY_STRUCT_BEG, tag);
			end
			tfs_pkg::ACT_STRUCT_END: begin
				enc = tfs_pkg::tfs_head(enc, tfs_pkg::TY_STRUCT_END, 8'd0);
			end
			tfs_pkg::ACT_LIST, tfs_pkg::ACT_MAP: begin
				if (length > tfs_pkg::COUNT_MAX) begin
					enc.err = 1'b1;
					enc     = tfs_pkg::tfs_put(enc, 8'h00);
				end else begin
					enc = tfs_pkg::tfs_head(enc, (action == tfs_pkg::ACT_LIST) ?
						tfs_pkg::TY_LIST : tfs_pkg::TY_MAP, tag);
					if (length[7:0] == 8'd0) begin
						enc = tfs_pkg::tfs_head(enc, tfs_pkg::TY_ZERO, 8'd0);
					end else begin
						enc = tfs_pkg::tfs_head(enc, tfs_pkg::TY_INT1, 8'd0);
						enc = tfs_pkg::tfs_put(enc, length[7:0]);
					end
				end
			end
			tfs_pkg::ACT_RAW: begin
				enc = tfs_pkg::tfs_put(enc, value[7:0]);
			end
			default: begin
				enc = '0;
			end
		endcase
	end

	// Move the first byte to the top so the sequencer can shift left.
	assign pad = tfs_pkg::TFS_CNT_W'(tfs_pkg::TFS_NBYTES) - enc.cnt;

	always_comb begin
		desc       = enc;
		desc.bytes = enc.bytes << {pad, 3'b000};
	end

endmodule

// ----- src/tfs_queue.sv -----
// Small queue of encoded transactions between the encoder and the sequencer.
module tfs_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  tfs_pkg::tfs_desc_t  wr_desc,
	input  logic                pop,
	output tfs_pkg::tfs_desc_t  rd_desc,
	output tfs_pkg::tfs_qstat_t stat
);

	tfs_pkg::tfs_desc_t                 slot_q [tfs_pkg::TFS_QDEPTH];
	logic [tfs_pkg::TFS_QPTR_W-1:0]     wr_ptr_q;
	logic [tfs_pkg::TFS_QPTR_W-1:0]     rd_ptr_q;
	logic [tfs_pkg::TFS_QCNT_W-1:0]     cnt_q;
	logic                               do_push;
	logic                               do_pop;

	assign stat.full  = (cnt_q == tfs_pkg::TFS_QCNT_W'(tfs_pkg::TFS_QDEPTH));
	assign stat.empty = (cnt_q == '0);
	assign stat.count = cnt_q;
	assign do_push    = push & ~stat.full;
	assign do_pop     = pop & ~stat.empty;
	assign rd_desc    = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wr_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + tfs_pkg::TFS_QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + tfs_pkg::TFS_QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + tfs_pkg::TFS_QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - tfs_pkg::TFS_QCNT_W'(1);
			end
		end
	end

endmodule

// ----- src/tfs_back.sv -----
// Byte sequencer: plays out one queued transaction, one byte per cycle.
module tfs_back (
	input  logic               clk,
	input  logic               arst_n,
	input  tfs_pkg::tfs_desc_t rd_desc,
	input  logic               q_empty,
	output logic               pop,
	output logic               strobe,
	output logic [7:0]         out_byte,
	output logic               last,
	output logic               error
);

	logic                                 active_q;
	logic [tfs_pkg::TFS_BYTES_W-1:0]      bytes_q;
	logic [tfs_pkg::TFS_CNT_W-1:0]        rem_q;
	logic                                 err_q;
	logic                                 final_byte;

	assign final_byte = (rem_q == tfs_pkg::TFS_CNT_W'(1));
	assign pop        = (~active_q | final_byte) & ~q_empty;

	assign strobe   = active_q;
	assign out_byte = bytes_q[tfs_pkg::TFS_BYTES_W-1 -: 8];
	assign last     = active_q & final_byte;
	assign error    = active_q & err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			rem_q    <= '0;
		end else if (pop) begin
			active_q <= 1'b1;
			rem_q    <= rd_desc.cnt;
		end else if (active_q && !final_byte) begin
			rem_q <= rem_q - tfs_pkg::TFS_CNT_W'(1);
		end else begin
			active_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			bytes_q <= rd_desc.bytes;
			err_q   <= rd_desc.err;
		end else if (active_q) begin
			bytes_q <= {bytes_q[tfs_pkg::TFS_BYTES_W-9:0], 8'h00};
		end
	end

endmodule

// ----- src/tagged_field_serializer.sv -----
// Tagged field serializer.
// Command channel: a transaction (action, tag, value, length) is taken at a
// rising edge where start is high and busy is low. busy rises only when the
// internal queue of four encoded transactions is full.
// Result channel: strobe marks one cycle in which out_byte, last and error are
// valid; the transaction is taken at the edge that ends that cycle. Each
// command yields one to ten bytes, the final one flagged by last. An illegal
// length yields a single byte of zero with both error and last set.
// Path: the first byte of a command that finds the block idle is written
// into a queue slot at the edge that takes the command and then loaded into
// the sequencer's byte register, which drives the result ports.
// Throughput: the byte sequencer emits exactly one byte per cycle and starts
// the next queued transaction directly after a last byte, so queued commands
// play out with no gap between them; the encoder accepts one command per
// cycle while the queue has room.
// The receiver cannot stall; results are never held back once started.
// Reset empties the queue and idles the sequencer; no results are pending.
`include "tagged_field_serializer_defines.svh"

module tagged_field_serializer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         action,
	input  logic [7:0]         tag,
	input  logic signed [63:0] value,
	input  logic [30:0]        length,
	output logic               strobe,
	output logic [7:0]         out_byte,
	output logic               last,
	output logic               error
);

	tfs_pkg::tfs_desc_t  enc_desc;
	tfs_pkg::tfs_desc_t  head_desc;
	tfs_pkg::tfs_qstat_t q_stat;
	logic                push;
	logic                pop;

	// Front: take the command and turn it into a left-justified byte sequence.
	tfs_front u_front (
		.start  (start),
		.busy   (busy),
		.action (action),
		.tag    (tag),
		.value  (value),
		.length (length),
		.q_stat (q_stat),
		.push   (push),
		.desc   (enc_desc)
	);

	// The queue decouples command acceptance from byte output.
	tfs_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_desc (enc_desc),
		.pop     (pop),
		.rd_desc (head_desc),
		.stat    (q_stat)
	);

	// Back: shift the bytes out, one per cycle.
	tfs_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_desc  (head_desc),
		.q_empty  (q_stat.empty),
		.pop      (pop),
		.strobe   (strobe),
		.out_byte (out_byte),
		.last     (last),
		.error    (error)
	);

	// An error result is always a single, final byte.
	`TFS_ASSERT_SAME(a_err_is_last, strobe && error, last && (out_byte == 8'h00), "error result without last")

	// The queue never holds more transactions than it has slots.
	`TFS_ASSERT_SAME(a_q_bound, 1'b1, q_stat.count <= tfs_pkg::TFS_QCNT_W'(tfs_pkg::TFS_QDEPTH), "queue overfilled")

	// A waiting transaction follows a last byte without a gap.
	`TFS_ASSERT_NEXT(a_no_bubble, strobe && last && !q_stat.empty, strobe, "gap between queued transactions")

	// A command taken while idle reaches strobe via a queue slot and the byte register.
	`TFS_ASSERT_NEXT(a_idle_latency, start && !busy && q_stat.empty && !strobe, ##1 strobe, "idle latency violated")

endmodule

// ----- tb/tagged_field_serializer_tb.sv -----
`timescale 1ns / 100ps

module tagged_field_serializer_tb;

	// Run shape. The directed table comes first, then the random commands.
	// The last stretch of commands is sent back to back with no idle cycles.
	localparam int N_DIRECTED   = 25;
	localparam int N_RANDOM     = 150;
	localparam int N_CALM       = 40;
	// Cycles with no command taken before the run is declared hung. A legal
	// stall is a full queue of four ten-byte transactions, so this is far
	// beyond any correct run.
	localparam int STALL_LIMIT  = 2000;
	// Extra cycles after the last expected byte, to catch stray output.
	localparam int DRAIN_CYCLES = 12;
	localparam int MAX_REPORTS  = 10;

	// One command as driven on the command ports. When typed is set, the
	// command yields exactly one byte whose value is given by t_byte and
	// t_err, and the predictor is bypassed.
	typedef struct packed {
		logic [2:0]  act;
		logic [7:0]  tg;
		logic [63:0] val;
		logic [30:0] len;
		logic        typed;
		logic [7:0]  t_byte;
		logic        t_err;
	} field_cmd_t;

	// One emitted byte with its flags.
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       err;
	} out_rec_t;

	// Directed commands: zero integers with tags 0 and 14, every integer width
	// at its edges, both tag forms, both string forms, and the length limits
	// of byte arrays, lists and maps. Rows whose bytes are obvious carry them.
	localparam field_cmd_t DIRECTED_CMDS [N_DIRECTED] = '{
		'{tfs_pkg::ACT_INT, 8'd0, 64'h0, 31'd0, 1'b1, 8'h0C, 1'b0},
		'{tfs_pkg::ACT_INT, 8'd14, 64'h0, 31'h7FFF_FFFF, 1'b1, 8'hEC, 1'b0},
		'{tfs_pkg::ACT_INT, 8'd15, 64'h1, 31'd0, 1'b0, 8'h00, 1'b0},
		'{tfs_pkg::ACT_INT, 8'd255, 64'hFFFF_FFFF_FFFF_FFFF, 31'd0, 1'b0, 8'h00, 1'b0},
		'{tfs_pkg::ACT_INT, 8'd1, 64'h7F, 31'd0, 1'b0, 8'h00, 1'b0},
		'{tfs_pkg::ACT_INT, 8'd2, 64'hFFFF_FFFF_FFFF_FF7F, 31'd0, 1'b0, 8'h00, 1'b0},
		'{tfs_pkg::ACT_INT, 8'd3, 64'h8000, 31'd0, 1'b0, 8'h00, 1'b0},
		'{tfs_pkg::ACT_INT, 8'd4, 64'hFFFF_FFFF_8000_0000, 31'd0, 1'b0, 8'h00, 1'b0},
		'{tfs_pkg::ACT_INT, 8'd5, 64'h0000_0000_8000_0000, 31'd0, 1'b0, 8'h00, 1'b0},
		'{tfs_pkg::ACT_INT, 8'd6, 64'h7FFF_FFFF_FFFF_FFFF, 31'd0, 1'b0, 8'h00, 1'b0},
		'{tfs_pkg::ACT_INT, 8'd200, 64'h8000_0000_0000_0000, 31'd0, 1'b0, 8'h00, 1'b0},
		'{tfs_pkg::ACT_STRING, 8'd7, 64'h0, 31'd0, 1'b0, 8'h00, 1'b0},
		'{tfs_pkg::ACT_STRING, 8'd15, 64'h0, 31'd255, 1'b0, 8'h00, 1'b0},
		'{tfs_pkg::ACT_STRING, 8'd8, 64'h0, 31'd256, 1'b0, 8'h00, 1'b0},
		'{tfs_pkg::ACT_STRING, 8'd255, 64'h0, 31'h7FFF_FFFF, 1'b0, 8'h00, 1'b0},
		'{tfs_pkg::ACT_BYTEARRAY, 8'd9, 64'h0, 31'd32767, 1'b0, 8'h00, 1'b0},
		'{tfs_pkg::ACT_BYTEARRAY, 8'd10, 64'h0, 31'd32768, 1'b1, 8'h00, 1'b1},
		'{tfs_pkg::ACT_BYTEARRAY, 8'd11, 64'h0, 31'h7FFF_FFFF, 1'b1, 8'h00, 1'b1},
		'{tfs_pkg::ACT_STRUCT_BEG, 8'd14, 64'h1234_5678_9ABC_DEF0, 31'd99, 1'b0, 8'h00, 1'b0},
		'{tfs_pkg::ACT_STRUCT_END, 8'd77, 64'h0, 31'd0, 1'b1, 8'h0B, 1'b0},
		'{tfs_pkg::ACT_LIST, 8'd12, 64'h0, 31'd255, 1'b0, 8'h00, 1'b0},
		'{tfs_pkg::ACT_LIST, 8'd13, 64'h0, 31'd256, 1'b1, 8'h00, 1'b1},
		'{tfs_pkg::ACT_MAP, 8'd15, 64'h0, 31'd0, 1'b0, 8'h00, 1'b0},
		'{tfs_pkg::ACT_MAP, 8'd1, 64'h0, 31'h7FFF_FFFF, 1'b1, 8'h00, 1'b1},
		'{tfs_pkg::ACT_RAW, 8'd0, 64'hFFFF_FFFF_FFFF_FFA5, 31'd0, 1'b0, 8'h00, 1'b0}
	};

	// Values on both sides of every integer width boundary.
	localparam logic [63:0] VALUE_EDGES [12] = '{
		64'h7F, 64'h80, 64'hFFFF_FFFF_FFFF_FF80, 64'hFFFF_FFFF_FFFF_FF7F,
		64'h7FFF, 64'h8000, 64'hFFFF_FFFF_FFFF_8000, 64'hFFFF_FFFF_FFFF_7FFF,
		64'h7FFF_FFFF, 64'h8000_0000, 64'hFFFF_FFFF_8000_0000, 64'hFFFF_FFFF_7FFF_FFFF
	};

	// Lengths at the string, count and byte-array limits.
	localparam logic [30:0] LENGTH_EDGES [9] = '{
		31'd0, 31'd1, 31'd127, 31'd128, 31'd255, 31'd256, 31'd32767, 31'd32768,
		31'h7FFF_FFFF
	};

	logic               clk = 1'b0;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [2:0]         action;
	logic [7:0]         tag;
	logic signed [63:0] value;
	logic [30:0]        length;
	logic               strobe;
	logic [7:0]         out_byte;
	logic               last;
	logic               error;

	// Typed expectation of the command on the ports, driven with it.
	logic               cur_typed;
	logic [7:0]         cur_t_byte;
	logic               cur_t_err;

	// Bytes still owed by the block, oldest first.
	out_rec_t   pending_bytes[$];
	// Scratch space while one command is being encoded.
	logic [7:0] enc_buf[$];
	int         bad_bytes    = 0;
	int         stall_cycles = 0;

	tagged_field_serializer i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.action   (action),
		.tag      (tag),
		.value    (value),
		.length   (length),
		.strobe   (strobe),
		.out_byte (out_byte),
		.last     (last),
		.error    (error)
	);

	always #5 clk = ~clk;

	// Head byte: type in the low nibble, tag in the high nibble. Tags of
	// fifteen and up are moved into a byte of their own after the head.
	function automatic void put_head(input logic [3:0] ty, input logic [7:0] tg);
		if (tg < tfs_pkg::TAG_ESC) begin
			enc_buf.push_back({tg[3:0], ty});
		end else begin
			enc_buf.push_back({tfs_pkg::TAG_ESC_NB, ty});
			enc_buf.push_back(tg);
		end
	endfunction

	// Integer in the narrowest signed form, payload big-endian.
	function automatic void put_int(input logic signed [63:0] v, input logic [7:0] tg);
		int         nbytes;
		logic [3:0] ty;
		if (v == 0) begin
			nbytes = 0;
			ty     = tfs_pkg::TY_ZERO;
		end else if (v >= -64'sd128 && v <= 64'sd127) begin
			nbytes = 1;
			ty     = tfs_pkg::TY_INT1;
		end else if (v >= -64'sd32768 && v <= 64'sd32767) begin
			nbytes = 2;
			ty     = tfs_pkg::TY_INT2;
		end else if (v >= -64'sd2147483648 && v <= 64'sd2147483647) begin
			nbytes = 4;
			ty     = tfs_pkg::TY_INT4;
		end else begin
			nbytes = 8;
			ty     = tfs_pkg::TY_INT8;
		end
		put_head(ty, tg);
		for (int i = nbytes - 1; i >= 0; i--) begin
			enc_buf.push_back(v[8*i +: 8]);
		end
	endfunction

	// Works out the bytes that one accepted command must produce and
	// appends them to the pending queue.
	function automatic void encode_field(input field_cmd_t c);
		logic        too_long;
		logic [31:0] len32;
		too_long = 1'b0;
		len32    = {1'b0, c.len};
		enc_buf.delete();
		case (c.act) inside
			tfs_pkg::ACT_INT: begin
				put_int(c.val, c.tg);
			end
			tfs_pkg::ACT_STRING: begin
				if (c.len > tfs_pkg::STR1_MAX) begin
					put_head(tfs_pkg::TY_STR4, c.tg);
					for (int i = 3; i >= 0; i--) begin
						enc_buf.push_back(len32[8*i +: 8]);
					end
				end else begin
					put_head(tfs_pkg::TY_STR1, c.tg);
					enc_buf.push_back(c.len[7:0]);
				end
			end
			tfs_pkg::ACT_BYTEARRAY: begin
				if (c.len > tfs_pkg::BARRAY_MAX) begin
					too_long = 1'b1;
				end else begin
					put_head(tfs_pkg::TY_SIMPLE, c.tg);
					put_head(tfs_pkg::TY_INT1, 8'd0);
					put_int(64'(c.len), 8'd0);
				end
			end
			tfs_pkg::ACT_STRUCT_BEG: begin
				put_head(tfs_pkg::TY_STRUCT_BEG, c.tg);
			end
			tfs_pkg::ACT_STRUCT_END: begin
				// The end marker never carries a tag.
				put_head(tfs_pkg::TY_STRUCT_END, 8'd0);
			end
			tfs_pkg::ACT_LIST, tfs_pkg::ACT_MAP: begin
				if (c.len > tfs_pkg::COUNT_MAX) begin
					too_long = 1'b1;
				end else begin
					put_head((c.act == tfs_pkg::ACT_LIST) ? tfs_pkg::TY_LIST :
						tfs_pkg::TY_MAP, c.tg);
					// The count stays one byte: 128 to 255 keep their bit
					// pattern instead of widening to a two-byte form.
					if (c.len == 0) begin
						put_head(tfs_pkg::TY_ZERO, 8'd0);
					end else begin
						put_head(tfs_pkg::TY_INT1, 8'd0);
						enc_buf.push_back(c.len[7:0]);
					end
				end
			end
			default: begin
				enc_buf.push_back(c.val[7:0]);
			end
		endcase
		if (too_long) begin
			pending_bytes.push_back('{8'h00, 1'b1, 1'b1});
		end else begin
			foreach (enc_buf[i]) begin
				pending_bytes.push_back('{enc_buf[i], i == enc_buf.size() - 1, 1'b0});
			end
		end
	endfunction

	function automatic void flag_mismatch(input string what, input out_rec_t want,
			input out_rec_t got);
		bad_bytes++;
		if (bad_bytes <= MAX_REPORTS) begin
			$display("%0t: %s: expected byte %h last %b error %b, got byte %h last %b error %b",
				$realtime, what, want.data, want.last, want.err,
				got.data, got.last, got.err);
		end
	endfunction

	// Random command. Integers are drawn by width class so that every form
	// is hit often, and lengths by range so that both sides of each limit
	// are hit; a share of draws lands exactly on the boundaries.
	function automatic field_cmd_t random_cmd();
		field_cmd_t         c;
		logic signed [63:0] v;
		int                 shift;
		c     = '0;
		c.act = 3'($urandom_range(0, 7));
		c.tg  = $urandom_range(0, 1) ? 8'($urandom_range(0, 14)) : 8'($urandom_range(0, 255));
		case ($urandom_range(0, 5)) inside
			0: begin
				c.val = 64'($urandom_range(0, 2)) - 64'd1;
			end
			[1:3]: begin
				shift = 64 - (8 << $urandom_range(0, 2));
				v     = {$urandom, $urandom};
				v     = (v <<< shift) >>> shift;
				c.val = v;
			end
			4: begin
				c.val = {$urandom, $urandom};
			end
			default: begin
				c.val = VALUE_EDGES[$urandom_range(0, 11)];
			end
		endcase
		case ($urandom_range(0, 3))
			0: begin
				c.len = 31'($urandom_range(0, 255));
			end
			1: begin
				c.len = 31'($urandom_range(256, 32767));
			end
			2: begin
				c.len = 31'($urandom);
				if (c.len < 31'd32768) begin
					c.len = c.len + 31'd32768;
				end
			end
			default: begin
				c.len = LENGTH_EDGES[$urandom_range(0, 8)];
			end
		endcase
		return c;
	endfunction

	// Puts a command on the ports and holds it until the block takes it.
	// start is left high, so the next command may follow with no gap.
	task automatic issue(input field_cmd_t c);
		@(negedge clk);
		start      <= 1'b1;
		action     <= c.act;
		tag        <= c.tg;
		value      <= c.val;
		length     <= c.len;
		cur_typed  <= c.typed;
		cur_t_byte <= c.t_byte;
		cur_t_err  <= c.t_err;
		@(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
	endtask

	// Keeps start low for the given number of cycles. The command fields
	// carry junk meanwhile, which the block must not pick up.
	task automatic pause_sender(input int cycles);
		@(negedge clk);
		start  <= 1'b0;
		action <= 3'($urandom);
		tag    <= 8'($urandom);
		value  <= {$urandom, $urandom};
		length <= 31'($urandom);
		repeat (cycles - 1) begin
			@(negedge clk);
		end
	endtask

	// Scoreboard. Ports are read at the rising edge, before the block's own
	// updates of that edge land, so these are the values the edge consumes.
	// A byte leaves the block only after its command went through the queue,
	// so the check of the emitted byte goes before the new prediction.
	always @(posedge clk) begin : byte_check
		field_cmd_t cmd;
		out_rec_t   got;
		if (arst_n) begin
			if (strobe) begin
				got = '{out_byte, last, error};
				if (pending_bytes.size() == 0) begin
					flag_mismatch("byte with nothing outstanding", '0, got);
				end else if (got !== pending_bytes[0]) begin
					flag_mismatch("wrong byte", pending_bytes.pop_front(), got);
				end else begin
					void'(pending_bytes.pop_front());
				end
			end
			if (start && !busy) begin
				cmd = '{action, tag, value, length, cur_typed, cur_t_byte, cur_t_err};
				if (cmd.typed) begin
					pending_bytes.push_back('{cmd.t_byte, 1'b1, cmd.t_err});
				end else begin
					encode_field(cmd);
				end
			end
		end
	end

	// Watchdog on command acceptance.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy)) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
		end
		if (stall_cycles >= STALL_LIMIT) begin
			$display("[tagged_field_serializer] ERROR");
			$finish;
		end
	end

	initial begin
		field_cmd_t cmd;
		int         n_cmds;
		arst_n     = 1'b0;
		start      = 1'b0;
		action     = tfs_pkg::ACT_INT;
		tag        = '0;
		value      = '0;
		length     = '0;
		cur_typed  = 1'b0;
		cur_t_byte = '0;
		cur_t_err  = 1'b0;
		repeat (11) begin
			@(posedge clk);
		end
		@(negedge clk);
		arst_n <= 1'b1;

		// The directed table, then random commands. Random idle bursts on the
		// command side fall anywhere in the block's work, except in the final
		// stretch, which runs the queue full against back-to-back commands.
		n_cmds = N_DIRECTED + N_RANDOM;
		for (int i = 0; i < n_cmds; i++) begin
			cmd = (i < N_DIRECTED) ? DIRECTED_CMDS[i] : random_cmd();
			issue(cmd);
			if (i < n_cmds - N_CALM && $urandom_range(0, 2) == 0) begin
				pause_sender($urandom_range(1, 14));
			end
		end
		@(negedge clk);
		start <= 1'b0;

		// Wait out the remaining bytes, then watch a little longer for strays.
		while (pending_bytes.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) begin
			@(posedge clk);
		end
		if (bad_bytes == 0 && pending_bytes.size() == 0) begin
			$display("[tagged_field_serializer] OK");
		end else begin
			$display("[tagged_field_serializer] ERROR");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+src
src/tfs_pkg.sv
src/tfs_front.sv
src/tfs_queue.sv
src/tfs_back.sv
src/tagged_field_serializer.sv
tb/tagged_field_serializer_tb.sv
